// ===== rtl/hmmfb_pkg.sv =====
// Package for the HMM forward belief update core.
// Holds state count, fixed-point tables and sequencer states.
// No dependencies.
package hmmfb_pkg;

    localparam int USER_COUNT = 16;
    localparam int NSTATE     = 7;
    localparam int USER_W     = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
    localparam int ST_W       = 3;
    localparam int MEM_DEPTH  = USER_COUNT * NSTATE;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIOR,
        S_LOAD,
        S_LOAD_WAIT,
        S_MAC,
        S_EMIT,
        S_DIV_START,
        S_DIV_RUN,
        S_NEXT,
        S_STORE,
        S_ARGMAX,
        S_OUT
    } t_state;

    // Transition probability, Q0.16, row = from, col = to.
    function automatic logic [15:0] trans_q(input logic [2:0] i, input logic [2:0] j);
        logic [15:0] r;
        r = 16'd0;
        case ({i, j})
            6'o00: r = 16'd19202; 6'o01: r = 16'd7930;  6'o02: r = 16'd4522;
            6'o03: r = 16'd3670;  6'o04: r = 16'd17170; 6'o05: r = 16'd8061;
            6'o06: r = 16'd4915;
            6'o10: r = 16'd10748; 6'o11: r = 16'd20513; 6'o12: r = 16'd4915;
            6'o13: r = 16'd3080;  6'o14: r = 16'd16515; 6'o15: r = 16'd6029;
            6'o16: r = 16'd3670;
            6'o20: r = 16'd6291;  6'o21: r = 16'd6029;  6'o22: r = 16'd18285;
            6'o23: r = 16'd3277;  6'o24: r = 16'd15991; 6'o25: r = 16'd8978;
            6'o26: r = 16'd6619;
            6'o30: r = 16'd1769;  6'o31: r = 16'd2097;  6'o32: r = 16'd2228;
            6'o33: r = 16'd27591; 6'o34: r = 16'd23724; 6'o35: r = 16'd3998;
            6'o36: r = 16'd3932;
            6'o40: r = 16'd2556;  6'o41: r = 16'd2753;  6'o42: r = 16'd3342;
            6'o43: r = 16'd13959; 6'o44: r = 16'd33358; 6'o45: r = 16'd5898;
            6'o46: r = 16'd3604;
            6'o50: r = 16'd7078;  6'o51: r = 16'd4456;  6'o52: r = 16'd4194;
            6'o53: r = 16'd5505;  6'o54: r = 16'd19399; 6'o55: r = 16'd20972;
            6'o56: r = 16'd3801;
            6'o60: r = 16'd5636;  6'o61: r = 16'd3146;  6'o62: r = 16'd4981;
            6'o63: r = 16'd12452; 6'o64: r = 16'd17302; 6'o65: r = 16'd5964;
            6'o66: r = 16'd15925;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Emission weight, Q0.16, by observation and state; class 3 is all zero.
    function automatic logic [15:0] emit_q(input logic [1:0] o, input logic [2:0] j);
        logic [15:0] r;
        r = 16'd0;
        case ({o, j})
            5'h00: r = 16'd39322; 5'h01: r = 16'd25428; 5'h02: r = 16'd27853;
            5'h03: r = 16'd59310; 5'h04: r = 16'd9372;  5'h05: r = 16'd17170;
            5'h06: r = 16'd40174;
            5'h08: r = 16'd18874; 5'h09: r = 16'd33620; 5'h0a: r = 16'd31130;
            5'h0b: r = 16'd4653;  5'h0c: r = 16'd11731; 5'h0d: r = 16'd46793;
            5'h0e: r = 16'd13959;
            5'h10: r = 16'd7406;  5'h11: r = 16'd6554;  5'h12: r = 16'd6554;
            5'h13: r = 16'd1573;  5'h14: r = 16'd44499; 5'h15: r = 16'd1573;
            5'h16: r = 16'd11469;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] prior_q(input logic [2:0] j);
        logic [15:0] r;
        case (j)
            3'd0: r = 16'd5439;
            3'd1: r = 16'd4784;
            3'd2: r = 16'd4588;
            3'd3: r = 16'd13173;
            3'd4: r = 16'd24773;
            3'd5: r = 16'd7733;
            3'd6: r = 16'd4981;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/hmmfb_div.sv =====
// Restoring divider, one quotient bit per cycle: q = num / den.
// Does not use hmmfb_pkg; fixed widths: 51-bit numerator, 35-bit divisor.
module hmmfb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [50:0] i_num,
    input  logic [34:0] i_den,
    output logic        o_done,
    output logic [50:0] o_quot
);
    logic [50:0] r_quot;
    logic [35:0] r_rem;
    logic [34:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] w_sh;

    // shift in next numerator bit
    assign w_sh = {r_rem[34:0], r_quot[50]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd50) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: compare and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= 36'd0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem  <= w_sh - {1'b0, r_den};
                r_quot <= {r_quot[49:0], 1'b1};
            end else begin
                r_rem  <= w_sh;
                r_quot <= {r_quot[49:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> !r_busy;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("div done while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 6'd50) else $error("div count overrun");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("div failed to start");
endmodule

// ===== rtl/hmm_forward_belief_update_core.sv =====
// HMM forward belief update core, top level.
// Uses hmmfb_pkg and hmmfb_div.
//
// Usage: one input word (user, observation, elapsed ticks) is taken on the
// i_valid/o_ready handshake; one result word (user echo, seven Q0.16 beliefs,
// most likely state) is offered on o_valid/i_ready. The core handles one word
// at a time and drops o_ready from acceptance until its result is taken.
// A pass clears the accumulators, then forms b[i] * T[i][j] for every (i, j) pair on one
// shared 16x16 multiplier, weights each state by its emission on the observation
// pass, and runs up to 7 divisions on one shared restoring divider.
// A word costs (ticks + 1) passes plus the loads of its seven beliefs, 7 stores and 6
// argmax steps; a first-seen user costs one pass.
// Beliefs live in a 112 x 16 memory with one read and one write port; the
// seen flags are flip-flops, so reset clears them at once and the core is
// ready the cycle after reset. While the receiver stalls the result is held
// and no new word is accepted.
module hmm_forward_belief_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_user_index,
    input  logic [1:0]  i_observation,
    input  logic [7:0]  i_elapsed_ticks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_user_echo,
    output logic [15:0] o_belief_angry,
    output logic [15:0] o_belief_disgust,
    output logic [15:0] o_belief_fear,
    output logic [15:0] o_belief_happy,
    output logic [15:0] o_belief_quiet,
    output logic [15:0] o_belief_sad,
    output logic [15:0] o_belief_surprise,
    output logic [2:0]  o_most_likely
);
    localparam int AW = hmmfb_pkg::MEM_AW;

    hmmfb_pkg::t_state r_state, n_state;

    logic [15:0] r_mem [hmmfb_pkg::MEM_DEPTH];
    logic [15:0] r_rdata;
    logic [hmmfb_pkg::USER_COUNT-1:0] r_seen;

    logic [15:0] r_b [hmmfb_pkg::NSTATE];
    logic [34:0] r_w [hmmfb_pkg::NSTATE];
    logic [34:0] r_sum;
    logic [3:0]  r_user;
    logic [1:0]  r_obs;
    logic [7:0]  r_ticks;
    logic        r_obs_pass;
    logic [2:0]  r_i, r_j;
    logic [2:0]  r_best;
    logic        r_kv;

    logic        w_div_start, w_div_done;
    logic [50:0] w_quot;
    logic [50:0] w_num;
    logic [AW-1:0] w_addr;
    logic [15:0] w_ma, w_mb;
    logic [31:0] w_prod;
    logic [34:0] w_emit;
    logic        w_last_i, w_last_j;

    // emission product: 35-bit belief weight by Q0.16, truncated back to 35 bits
    function automatic logic [34:0] emit_mul(input logic [34:0] w, input logic [15:0] e);
        logic [50:0] p;
        p = {16'd0, w} * {35'd0, e};
        return p[50:16];
    endfunction

    assign w_last_i = (r_i == 3'(hmmfb_pkg::NSTATE - 1));
    assign w_last_j = (r_j == 3'(hmmfb_pkg::NSTATE - 1));
    assign w_addr   = AW'(r_user) * AW'(hmmfb_pkg::NSTATE) + AW'(r_j);

    // shared multiplier operands
    assign w_ma   = r_b[r_i];
    assign w_mb   = hmmfb_pkg::trans_q(r_i, r_j);
    assign w_prod = w_ma * w_mb;
    assign w_emit = emit_mul(r_w[r_j], hmmfb_pkg::emit_q(r_obs, r_j));

    // numerator (w << 16) + sum/2 for the shared divider
    assign w_num = {r_w[r_j], 16'd0} + {17'd0, r_sum[34:1]};

    hmmfb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_div_start = (r_state == hmmfb_pkg::S_DIV_START);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hmmfb_pkg::S_IDLE:
                if (i_valid) begin
                    if (!r_seen[i_user_index]) n_state = hmmfb_pkg::S_PRIOR;
                    else                       n_state = hmmfb_pkg::S_LOAD;
                end
            hmmfb_pkg::S_PRIOR:     n_state = hmmfb_pkg::S_MAC;
            hmmfb_pkg::S_LOAD:      n_state = hmmfb_pkg::S_LOAD_WAIT;
            hmmfb_pkg::S_LOAD_WAIT:
                if (w_last_j) n_state = hmmfb_pkg::S_MAC;
                else          n_state = hmmfb_pkg::S_LOAD;
            hmmfb_pkg::S_MAC:
                if (r_kv && w_last_j && w_last_i) begin
                    if (r_obs_pass) n_state = hmmfb_pkg::S_EMIT;
                    else            n_state = hmmfb_pkg::S_DIV_START;
                end
            hmmfb_pkg::S_EMIT:
                if (r_kv && w_last_j) n_state = hmmfb_pkg::S_DIV_START;
            hmmfb_pkg::S_DIV_START:
                if (r_sum == 35'd0) n_state = hmmfb_pkg::S_NEXT;
                else                n_state = hmmfb_pkg::S_DIV_RUN;
            hmmfb_pkg::S_DIV_RUN:
                if (w_div_done) begin
                    if (w_last_j) n_state = hmmfb_pkg::S_NEXT;
                    else          n_state = hmmfb_pkg::S_DIV_START;
                end
            hmmfb_pkg::S_NEXT:
                if (r_obs_pass) n_state = hmmfb_pkg::S_STORE;
                else            n_state = hmmfb_pkg::S_MAC;
            hmmfb_pkg::S_STORE:
                if (w_last_j) n_state = hmmfb_pkg::S_ARGMAX;
            hmmfb_pkg::S_ARGMAX:
                if (w_last_j) n_state = hmmfb_pkg::S_OUT;
            hmmfb_pkg::S_OUT:
                if (i_ready) n_state = hmmfb_pkg::S_IDLE;
            default: n_state = hmmfb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= hmmfb_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // seen flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seen <= '0;
        else if (r_state == hmmfb_pkg::S_IDLE && i_valid) r_seen[i_user_index] <= 1'b1;
    end

    // belief memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == hmmfb_pkg::S_STORE) r_mem[w_addr] <= r_b[r_j];
        r_rdata <= r_mem[w_addr];
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            hmmfb_pkg::S_IDLE: begin
                r_user <= i_user_index;
                r_obs  <= i_observation;
                r_ticks <= r_seen[i_user_index] ? i_elapsed_ticks : 8'd0;
                r_obs_pass <= r_seen[i_user_index] ? (i_elapsed_ticks == 8'd0) : 1'b1;
                r_i <= 3'd0;
                r_j <= 3'd0;
                r_kv <= 1'b0;
                r_sum <= 35'd0;
            end
            hmmfb_pkg::S_PRIOR: begin
                for (int k = 0; k < hmmfb_pkg::NSTATE; k++)
                    r_b[k] <= hmmfb_pkg::prior_q(3'(k));
            end
            hmmfb_pkg::S_LOAD_WAIT: begin
                r_b[r_j] <= r_rdata;
                r_j <= w_last_j ? 3'd0 : r_j + 3'd1;
            end
            hmmfb_pkg::S_MAC: begin
                // clear on entry, then accumulate b[i] * T[i][j] for each (i, j)
                if (!r_kv) begin
                    r_kv <= 1'b1;
                    for (int k = 0; k < hmmfb_pkg::NSTATE; k++) r_w[k] <= 35'd0;
                    r_sum <= 35'd0;
                end else begin
                    r_w[r_j] <= r_w[r_j] + 35'(w_prod);
                    r_sum <= r_sum + 35'(w_prod);
                    if (w_last_i) begin
                        r_i <= 3'd0;
                        r_j <= w_last_j ? 3'd0 : r_j + 3'd1;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                    if (w_last_i && w_last_j) r_kv <= 1'b0;
                end
            end
            hmmfb_pkg::S_EMIT: begin
                // w[j] * E >> 16, truncated; one step issues, next stores
                if (!r_kv) begin
                    r_kv <= 1'b1;
                    r_sum <= (r_j == 3'd0) ? 35'd0 : r_sum;
                end else begin
                    r_kv <= 1'b0;
                    r_w[r_j] <= w_emit;
                    r_sum <= r_sum + w_emit;
                    r_j <= w_last_j ? 3'd0 : r_j + 3'd1;
                end
            end
            hmmfb_pkg::S_DIV_RUN: begin
                if (w_div_done) begin
                    r_b[r_j] <= (w_quot > 51'd65535) ? 16'hFFFF : w_quot[15:0];
                    r_j <= w_last_j ? 3'd0 : r_j + 3'd1;
                end
            end
            hmmfb_pkg::S_NEXT: begin
                r_j <= 3'd0;
                r_i <= 3'd0;
                r_kv <= 1'b0;
                if (!r_obs_pass) begin
                    r_ticks <= r_ticks - 8'd1;
                    if (r_ticks == 8'd1) r_obs_pass <= 1'b1;
                end
            end
            hmmfb_pkg::S_STORE: begin
                r_j <= w_last_j ? 3'd1 : r_j + 3'd1;
                r_best <= 3'd0;
            end
            hmmfb_pkg::S_ARGMAX: begin
                if (r_b[r_j] > r_b[r_best]) r_best <= r_j;
                r_j <= w_last_j ? 3'd0 : r_j + 3'd1;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == hmmfb_pkg::S_IDLE);
    assign o_valid = (r_state == hmmfb_pkg::S_OUT);
    assign o_user_echo       = r_user;
    assign o_belief_angry    = r_b[0];
    assign o_belief_disgust  = r_b[1];
    assign o_belief_fear     = r_b[2];
    assign o_belief_happy    = r_b[3];
    assign o_belief_quiet    = r_b[4];
    assign o_belief_sad      = r_b[5];
    assign o_belief_surprise = r_b[6];
    assign o_most_likely     = r_best;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_most_likely)))
        else $error("result dropped under stall");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_seen_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> r_seen[r_user]) else $error("user not marked seen");
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_best <= 3'd6) else $error("argmax out of range");
endmodule

// ===== verif/testbench.sv =====
// Testbench for hmm_forward_belief_update_core: drives user/observation/tick
// words and checks each belief result against an in-bench forward filter.
// Depends on hmmfb_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [3:0]  user;
        logic [15:0] b0, b1, b2, b3, b4, b5, b6;
        logic [2:0]  best;
    } t_belief_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_user_index = '0;
    logic [1:0]  i_observation = '0;
    logic [7:0]  i_elapsed_ticks = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_user_echo;
    logic [15:0] o_belief_angry, o_belief_disgust, o_belief_fear, o_belief_happy;
    logic [15:0] o_belief_quiet, o_belief_sad, o_belief_surprise;
    logic [2:0]  o_most_likely;

    // Filter state held by the bench
    logic [15:0]  model_belief [16][7];
    bit           model_seen [16];
    t_belief_word expected_beliefs [$];
    int           error_count = 0;
    bit           sender_calm = 0;
    bit           receiver_calm = 0;
    int           hold_off_cycles = 0;

    hmm_forward_belief_update_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Transition constants, Q0.16, from the decimal probabilities
    function automatic logic [15:0] q16(input int milli);
        return 16'((milli * 65536 + 500) / 1000);
    endfunction

    function automatic logic [15:0] trans_at(input int i, input int j);
        int t [7][7] = '{'{293, 121, 69, 56, 262, 123, 75},
                         '{164, 313, 75, 47, 252, 92, 56},
                         '{96, 92, 279, 50, 244, 137, 101},
                         '{27, 32, 34, 421, 362, 61, 60},
                         '{39, 42, 51, 213, 509, 90, 55},
                         '{108, 68, 64, 84, 296, 320, 58},
                         '{86, 48, 76, 190, 264, 91, 243}};
        return q16(t[i][j]);
    endfunction

    function automatic logic [15:0] emit_at(input int o, input int j);
        int e [3][7] = '{'{600, 388, 425, 905, 143, 262, 613},
                         '{288, 513, 475, 71, 179, 714, 213},
                         '{113, 100, 100, 24, 679, 24, 175}};
        if (o > 2) return 16'd0;
        return q16(e[o][j]);
    endfunction

    // One pass through the transition matrix, optional emission weighting
    task automatic propagate_user(input int u, input bit weigh, input int obs);
        logic [63:0] w [7];
        logic [63:0] total, q;
        total = 0;
        for (int j = 0; j < 7; j++) begin
            w[j] = 0;
            for (int i = 0; i < 7; i++)
                w[j] += 64'(model_belief[u][i]) * trans_at(i, j);
            if (weigh) w[j] = (w[j] * emit_at(obs, j)) >> 16;
            total += w[j];
        end
        if (total != 0) begin
            for (int j = 0; j < 7; j++) begin
                q = ((w[j] << 16) + total / 2) / total;
                model_belief[u][j] = (q > 65535) ? 16'hFFFF : q[15:0];
            end
        end
    endtask

    task automatic predict_belief(input int u, input int obs, input int ticks);
        int prior [7] = '{83, 73, 70, 201, 378, 118, 76};
        int best;
        t_belief_word r;
        best = 0;
        if (!model_seen[u]) begin
            for (int j = 0; j < 7; j++) model_belief[u][j] = q16(prior[j]);
            model_seen[u] = 1;
            ticks = 0;
        end
        for (int t = 0; t < ticks; t++) propagate_user(u, 0, 0);
        propagate_user(u, 1, obs);
        for (int j = 1; j < 7; j++)
            if (model_belief[u][j] > model_belief[u][best]) best = j;
        r.user = 4'(u);
        r.b0 = model_belief[u][0]; r.b1 = model_belief[u][1];
        r.b2 = model_belief[u][2]; r.b3 = model_belief[u][3];
        r.b4 = model_belief[u][4]; r.b5 = model_belief[u][5];
        r.b6 = model_belief[u][6]; r.best = 3'(best);
        expected_beliefs.push_back(r);
    endtask

    // Offer one word, hold it until accepted, then drop valid
    task automatic send_word(input int u, input int obs, input int ticks);
        @(negedge i_clk);
        while (!sender_calm && $urandom_range(99) < 36) @(negedge i_clk);
        i_user_index <= 4'(u);
        i_observation <= 2'(obs);
        i_elapsed_ticks <= 8'(ticks);
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_belief(u, obs, ticks);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Receiver readiness
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= receiver_calm || ($urandom_range(99) >= 36);
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_belief_word got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_user_echo, o_belief_angry, o_belief_disgust, o_belief_fear,
                   o_belief_happy, o_belief_quiet, o_belief_sad, o_belief_surprise,
                   o_most_likely};
            if (expected_beliefs.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = expected_beliefs.pop_front();
                if (got.user != want.user || got.b0 != want.b0 || got.b1 != want.b1 ||
                    got.b2 != want.b2 || got.b3 != want.b3 || got.b4 != want.b4 ||
                    got.b5 != want.b5 || got.b6 != want.b6 || got.best != want.best) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    task automatic test_first_seen_and_extremes();
        send_word(0, 0, 255);
        send_word(15, 2, 0);
        send_word(0, 0, 0);
        send_word(0, 1, 1);
        send_word(0, 2, 255);
        send_word(15, 3, 3);
        send_word(15, 3, 0);
        send_word(5, 3, 9);
        send_word(5, 1, 170);
        send_word(10, 2, 85);
    endtask

    // Hold results off while the sender keeps offering
    task automatic test_backpressure();
        while (expected_beliefs.size() != 0) @(negedge i_clk);
        hold_off_cycles = 3000;
        for (int k = 0; k < 4; k++) send_word($urandom_range(15), $urandom_range(2), 1);
    endtask

    task automatic test_random_words();
        int ticks;
        for (int k = 0; k < 95; k++) begin
            sender_calm = (k >= 30 && k < 50);
            receiver_calm = sender_calm;
            // mostly short gaps; a few long ones
            ticks = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(4);
            send_word($urandom_range(15), ($urandom_range(19) == 0) ? 3 : $urandom_range(2),
                      ticks);
        end
        sender_calm = 0;
        receiver_calm = 0;
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_first_seen_and_extremes();
        test_backpressure();
        test_random_words();
        while (expected_beliefs.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (error_count == 0 && expected_beliefs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #250ms;
        $display("simulation failed");
        $finish;
    end
endmodule
